### hw/rtl/shwmm_pkg.sv
// Shared types and constants for the sample history window min/max unit.
package shwmm_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int INDEX_BITS    = 32;
  localparam int TOTAL_BITS    = 32;
  localparam int FILL_BITS     = 10;
  localparam int DEPTH_DEFAULT = 512;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic                          req_type;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [INDEX_BITS-1:0]         read_index;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] read_value;
    logic                          read_valid;
    logic signed [SAMPLE_BITS-1:0] window_min;
    logic signed [SAMPLE_BITS-1:0] window_max;
    logic [FILL_BITS-1:0]          fill_count;
    logic [TOTAL_BITS-1:0]         total_samples;
  } out_word_t;

  typedef struct packed {
    logic                          is_read;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [INDEX_BITS-1:0]         read_index;
  } cmd_t;

endpackage

### hw/rtl/shwmm_front.sv
// Front end: accepts request words, classifies them and queues them for the back end.
module shwmm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  shwmm_pkg::in_word_t in_data,
  output logic                cmd_valid,
  output shwmm_pkg::cmd_t     cmd,
  input  logic                cmd_pop
);

  shwmm_pkg::cmd_t q [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      used;
  logic            push;
  shwmm_pkg::cmd_t cls;

  assign in_ready  = (used != 2'd2);
  assign push      = in_valid & in_ready;
  assign cmd_valid = (used != 2'd0);
  assign cmd       = q[rd_ptr];

  always_comb begin
    cls.is_read    = (in_data.req_type == shwmm_pkg::REQ_READ);
    cls.sample     = in_data.sample;
    cls.read_index = in_data.read_index;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, cmd_pop})
        2'b10:   used <= used + 2'd1;
        2'b01:   used <= used - 2'd1;
        default: used <= used;
      endcase
    end
  end

endmodule

### hw/rtl/shwmm_back.sv
// Back end: ring memory, counters, window scan and result register.
module shwmm_back #(
  parameter int DEPTH = shwmm_pkg::DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  input  shwmm_pkg::cmd_t      cmd,
  output logic                 cmd_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output shwmm_pkg::out_word_t out_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = PW + 2;
  localparam int SB = shwmm_pkg::SAMPLE_BITS;
  localparam int TB = shwmm_pkg::TOTAL_BITS;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_RD_CALC  = 3'd1;
  localparam logic [2:0] ST_RD_ISSUE = 3'd2;
  localparam logic [2:0] ST_RD_DATA  = 3'd3;
  localparam logic [2:0] ST_SCAN     = 3'd4;

  logic signed [SB-1:0] mem [DEPTH];
  logic signed [SB-1:0] rd_data;
  logic                 mem_we;
  logic [PW-1:0]        mem_addr;
  logic signed [SB-1:0] mem_wdata;

  logic [2:0]           state, state_next;
  logic [PW-1:0]        wp, wp_next;
  logic [CW-1:0]        count, count_next;
  logic [TB-1:0]        total, total_next;
  logic signed [SB-1:0] cur_min, cur_min_next;
  logic signed [SB-1:0] cur_max, cur_max_next;
  logic [shwmm_pkg::INDEX_BITS-1:0] idx, idx_next;
  logic [PW-1:0]        delta, delta_next;
  logic                 inwin, inwin_next;
  logic [CW-1:0]        scan_idx, scan_idx_next;
  logic                 rd_pend, rd_pend_next;
  logic                 out_valid_next;
  shwmm_pkg::out_word_t out_data_next;

  logic                 out_free;
  logic                 load;
  shwmm_pkg::out_word_t res;
  logic [TB-1:0]        d_full;
  logic [SW-1:0]        slot_sum;
  logic [SW-1:0]        slot;
  logic signed [SB-1:0] scan_min;
  logic signed [SB-1:0] scan_max;

  assign out_free = ~out_valid | out_ready;

  always_comb begin
    d_full   = idx - (total - TB'(count));
    slot_sum = SW'(wp) + SW'(DEPTH) - SW'(count) + SW'(delta);
    slot     = (slot_sum >= SW'(DEPTH)) ? (slot_sum - SW'(DEPTH)) : slot_sum;
    scan_min = (rd_pend && (rd_data < cur_min)) ? rd_data : cur_min;
    scan_max = (rd_pend && (rd_data > cur_max)) ? rd_data : cur_max;
  end

  always_comb begin
    state_next    = state;
    wp_next       = wp;
    count_next    = count;
    total_next    = total;
    cur_min_next  = cur_min;
    cur_max_next  = cur_max;
    idx_next      = idx;
    delta_next    = delta;
    inwin_next    = inwin;
    scan_idx_next = scan_idx;
    rd_pend_next  = 1'b0;
    cmd_pop       = 1'b0;
    mem_we        = 1'b0;
    mem_addr      = wp;
    mem_wdata     = cmd.sample;
    load          = 1'b0;
    res.read_value    = '0;
    res.read_valid    = 1'b0;
    res.window_min    = cur_min;
    res.window_max    = cur_max;
    res.fill_count    = shwmm_pkg::FILL_BITS'(count);
    res.total_samples = total;

    case (state)
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          if (cmd.is_read) begin
            idx_next   = cmd.read_index;
            state_next = ST_RD_CALC;
          end else begin
            mem_we     = 1'b1;
            wp_next    = (wp == PW'(DEPTH - 1)) ? '0 : wp + PW'(1);
            count_next = (count == CW'(DEPTH)) ? count : count + CW'(1);
            total_next = total + TB'(1);
            if (count_next == CW'(DEPTH)) begin
              cur_min_next  = shwmm_pkg::SAMPLE_MAX;
              cur_max_next  = shwmm_pkg::SAMPLE_MIN;
              scan_idx_next = '0;
              state_next    = ST_SCAN;
            end else begin
              cur_min_next = (cmd.sample < cur_min) ? cmd.sample : cur_min;
              cur_max_next = (cmd.sample > cur_max) ? cmd.sample : cur_max;
              load              = 1'b1;
              res.window_min    = cur_min_next;
              res.window_max    = cur_max_next;
              res.fill_count    = shwmm_pkg::FILL_BITS'(count_next);
              res.total_samples = total_next;
            end
          end
        end
      end
      ST_RD_CALC: begin
        inwin_next = (d_full < TB'(count));
        delta_next = PW'(d_full);
        state_next = ST_RD_ISSUE;
      end
      ST_RD_ISSUE: begin
        if (inwin) begin
          mem_addr   = PW'(slot);
          state_next = ST_RD_DATA;
        end else begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_RD_DATA: begin
        load           = 1'b1;
        res.read_value = rd_data;
        res.read_valid = 1'b1;
        state_next     = ST_IDLE;
      end
      ST_SCAN: begin
        cur_min_next = scan_min;
        cur_max_next = scan_max;
        if (scan_idx == CW'(DEPTH)) begin
          load           = 1'b1;
          res.window_min = scan_min;
          res.window_max = scan_max;
          state_next     = ST_IDLE;
        end else begin
          mem_addr      = PW'(scan_idx);
          rd_pend_next  = 1'b1;
          scan_idx_next = scan_idx + CW'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    out_valid_next = out_valid & ~out_ready;
    out_data_next  = out_data;
    if (load) begin
      out_valid_next = 1'b1;
      out_data_next  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    delta    <= delta_next;
    inwin    <= inwin_next;
    scan_idx <= scan_idx_next;
    out_data <= out_data_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wp        <= '0;
      count     <= '0;
      total     <= '0;
      cur_min   <= shwmm_pkg::SAMPLE_MAX;
      cur_max   <= shwmm_pkg::SAMPLE_MIN;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      wp        <= wp_next;
      count     <= count_next;
      total     <= total_next;
      cur_min   <= cur_min_next;
      cur_max   <= cur_max_next;
      rd_pend   <= rd_pend_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### hw/rtl/sample_history_window_min_max_unit.sv
// Sample history window: push samples into a ring, read back by global index, track min/max.
//
// Input channel in_valid/in_ready/in_data carries one request word: a push of a
// signed sample or a read by global sample number. Output channel
// out_valid/out_ready/out_data returns one result word per request: the read-back
// value and flag, the window min/max, the fill count and the push total.
// A two-entry queue sits between the front end and the back end, so requests are
// taken while a result waits at the output.
// A push into a ring that is not yet full is answered from the running min/max;
// a read passes a window check and a memory read (no memory read when the index
// is outside the window). A push that fills or overwrites the ring rescans the
// single-port ring memory, one memory read per cycle; once the ring is full this
// scan paces pushes, as the back end takes no new request until it is done.
// Reset empties the ring at once (no clearing pass): fill count and total go to
// zero, min to the most positive and max to the most negative sample value.
// When out_ready is low the result is held and the back end waits; the front
// queue keeps accepting until it holds two words.
module sample_history_window_min_max_unit #(
  parameter int DEPTH = shwmm_pkg::DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  shwmm_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output shwmm_pkg::out_word_t out_data
);

  logic            cmd_valid;
  logic            cmd_pop;
  shwmm_pkg::cmd_t cmd;

  shwmm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  shwmm_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_pop_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (cmd_valid && (!out_valid || out_ready)))
    else $error("back end took a command while the result register was blocked");

  a_invalid_read_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.read_valid) |-> (out_data.read_value == '0))
    else $error("read value not zero without a valid read");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.total_samples != '0)) |->
      (out_data.window_min <= out_data.window_max))
    else $error("window min above window max");

endmodule

### tb/tb_sample_history_window_min_max_unit.sv
// Testbench for the sample history window min/max unit: directed and random push/read traffic vs a ring model.
module tb_sample_history_window_min_max_unit;

  localparam int DEPTH        = shwmm_pkg::DEPTH_DEFAULT;
  localparam int PW           = $clog2(DEPTH);
  localparam int DRAIN_CYCLES = DEPTH + 64;
  localparam int RUN_LIMIT    = 100_000_000;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid;
  logic                 in_ready;
  shwmm_pkg::in_word_t  in_data;
  logic                 out_valid;
  logic                 out_ready;
  shwmm_pkg::out_word_t out_data;

  // predicted ring state
  logic signed [shwmm_pkg::SAMPLE_BITS-1:0] ring_mem [DEPTH];
  int unsigned                              ring_wr    = 0;
  int unsigned                              ring_held  = 0;
  logic [shwmm_pkg::TOTAL_BITS-1:0]         ring_total = '0;
  logic signed [shwmm_pkg::SAMPLE_BITS-1:0] ring_lo    = shwmm_pkg::SAMPLE_MAX;
  logic signed [shwmm_pkg::SAMPLE_BITS-1:0] ring_hi    = shwmm_pkg::SAMPLE_MIN;
  shwmm_pkg::out_word_t                     expected_q [$];
  shwmm_pkg::out_word_t                     oldest_w;

  // stimulus bookkeeping
  int unsigned pushes_sent     = 0;
  int unsigned words_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned fail_count      = 0;
  bit          tx_idle_on      = 1'b1;
  bit          rx_idle_on      = 1'b1;
  int unsigned rx_stall_len    = 0;

  sample_history_window_min_max_unit #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("sample_history_window_min_max_unit test failed");
    $finish;
  end

  function automatic shwmm_pkg::out_word_t predict_result(shwmm_pkg::in_word_t w);
    shwmm_pkg::out_word_t r;
    logic [31:0]          offset;
    r = '0;
    if (w.req_type == shwmm_pkg::REQ_PUSH) begin
      ring_mem[PW'(ring_wr)] = w.sample;
      ring_wr = (ring_wr + 1) % DEPTH;
      if (ring_held < DEPTH) ring_held++;
      ring_total = ring_total + 1'b1;
      if (ring_held == DEPTH) begin
        ring_lo = shwmm_pkg::SAMPLE_MAX;
        ring_hi = shwmm_pkg::SAMPLE_MIN;
        foreach (ring_mem[i]) begin
          if (ring_mem[i] < ring_lo) ring_lo = ring_mem[i];
          if (ring_mem[i] > ring_hi) ring_hi = ring_mem[i];
        end
      end else begin
        if (w.sample < ring_lo) ring_lo = w.sample;
        if (w.sample > ring_hi) ring_hi = w.sample;
      end
    end else begin
      offset = w.read_index - (ring_total - ring_held);
      if (offset < ring_held) begin
        r.read_value = ring_mem[PW'((ring_wr + DEPTH - ring_held + offset) % DEPTH)];
        r.read_valid = 1'b1;
      end
    end
    r.window_min    = ring_lo;
    r.window_max    = ring_hi;
    r.fill_count    = shwmm_pkg::FILL_BITS'(ring_held);
    r.total_samples = ring_total;
    return r;
  endfunction

  task automatic check_field(string name, logic signed [32:0] exp_v, logic signed [32:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) expected_q.push_back(predict_result(in_data));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result word with no request pending");
          fail_count++;
        end else begin
          oldest_w = expected_q.pop_front();
          check_field("read_value", 33'(oldest_w.read_value), 33'(out_data.read_value));
          check_field("read_valid", 33'(oldest_w.read_valid), 33'(out_data.read_valid));
          check_field("window_min", 33'(oldest_w.window_min), 33'(out_data.window_min));
          check_field("window_max", 33'(oldest_w.window_max), 33'(out_data.window_max));
          check_field("fill_count", 33'(oldest_w.fill_count), 33'(out_data.fill_count));
          check_field("total_samples", 33'(oldest_w.total_samples),
                      33'(out_data.total_samples));
          results_checked++;
        end
      end
    end
  end

  // receiver: random ready gaps, plus a long hold-off on request
  initial begin
    int unsigned gap;
    out_ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (rx_stall_len > 0) begin
        out_ready <= 1'b0;
        repeat (rx_stall_len) @(posedge clk);
        rx_stall_len = 0;
      end
      gap = rx_idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_word(shwmm_pkg::in_word_t w);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (w.req_type == shwmm_pkg::REQ_PUSH) pushes_sent++;
  endtask

  task automatic send_push(logic signed [shwmm_pkg::SAMPLE_BITS-1:0] s);
    shwmm_pkg::in_word_t w;
    w.req_type   = shwmm_pkg::REQ_PUSH;
    w.sample     = s;
    w.read_index = $urandom;
    send_word(w);
  endtask

  task automatic send_read(logic [shwmm_pkg::INDEX_BITS-1:0] idx);
    shwmm_pkg::in_word_t w;
    w.req_type   = shwmm_pkg::REQ_READ;
    w.sample     = shwmm_pkg::SAMPLE_BITS'($urandom);
    w.read_index = idx;
    send_word(w);
  endtask

  function automatic logic signed [shwmm_pkg::SAMPLE_BITS-1:0] random_sample();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return shwmm_pkg::SAMPLE_MAX;
    if (pick == 1) return shwmm_pkg::SAMPLE_MIN;
    return shwmm_pkg::SAMPLE_BITS'($urandom);
  endfunction

  function automatic logic [shwmm_pkg::INDEX_BITS-1:0] random_read_index();
    int unsigned                      held;
    int unsigned                      pick;
    logic [shwmm_pkg::INDEX_BITS-1:0] base;
    held = (pushes_sent < DEPTH) ? pushes_sent : DEPTH;
    base = pushes_sent - held;
    pick = $urandom_range(0, 9);
    if (held > 0 && pick <= 5) return base + $urandom_range(0, held - 1);
    if (pick == 6) return base - 1;
    if (pick == 7) return base + held;
    if (held > 0 && pick == 9) return ($urandom_range(0, 1) != 0) ? base : base + held - 1;
    return $urandom;
  endfunction

  task automatic test_empty_reads();
    send_read('0);
    send_read('1);
    send_read(32'h8000_0000);
  endtask

  task automatic test_push_extremes();
    send_push(shwmm_pkg::SAMPLE_MAX);
    send_push(shwmm_pkg::SAMPLE_MIN);
    send_push('0);
    send_push('1);
    send_push(16'sd1);
    send_read(32'd0);
    send_read(32'd4);
    send_read(32'd5);
    send_read('1);
  endtask

  // hold the receiver off while gap-free pushes fill the block and stall its input
  task automatic test_input_stall();
    tx_idle_on   = 1'b0;
    rx_idle_on   = 1'b0;
    rx_stall_len = 300;
    repeat (16) send_push(random_sample());
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_fill_random();
    int unsigned n;
    int unsigned phase;
    n = 0;
    while (pushes_sent < DEPTH) begin
      phase      = n % 160;
      tx_idle_on = phase >= 40;
      rx_idle_on = phase >= 40 && (phase < 100 || phase >= 140);
      if ($urandom_range(0, 9) < 7) send_push(random_sample());
      else send_read(random_read_index());
      n++;
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_full_window_edges();
    logic [shwmm_pkg::INDEX_BITS-1:0] base;
    base = pushes_sent - DEPTH;
    send_read(base);
    send_read(base + DEPTH - 1);
    send_read(base - 1);
    send_read(base + DEPTH);
    send_push(shwmm_pkg::SAMPLE_MIN);
    send_read(pushes_sent - 1);
  endtask

  task automatic test_full_random();
    int unsigned n;
    for (n = 0; n < 400; n++) begin
      tx_idle_on = (n % 100) >= 20;
      rx_idle_on = (n % 100) >= 20;
      if ($urandom_range(0, 3) == 0) send_push(random_sample());
      else send_read(random_read_index());
    end
  endtask

  initial begin
    in_valid = 1'b0;
    in_data  = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_reads();
    test_push_extremes();
    test_input_stall();
    test_fill_random();
    test_full_window_edges();
    test_full_random();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d request words (%0d pushes, %0d reads); checked %0d result words.",
             words_sent, pushes_sent, words_sent - pushes_sent, results_checked);
    $display("Covered empty reads, sample extremes, output hold-off, ring fill and wrap.");
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("sample_history_window_min_max_unit test passed");
    end else begin
      $display("sample_history_window_min_max_unit test failed");
    end
    $finish;
  end

endmodule

### sample_history_window_min_max_unit.f
hw/rtl/shwmm_pkg.sv
hw/rtl/shwmm_front.sv
hw/rtl/shwmm_back.sv
hw/rtl/sample_history_window_min_max_unit.sv
tb/tb_sample_history_window_min_max_unit.sv
